// File: hw/rtl/rht_pkg.sv
// ----------------------------------------------------------------------------
// rht_pkg
// Shared types and constants for the reference-counted handle table.
// ----------------------------------------------------------------------------
package rht_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int HANDLE_W     = 32;
    localparam int COUNT_W      = 16;
    localparam int FUNC_W       = 2;
    localparam int STATUS_W     = 3;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [FUNC_W-1:0] {
        FN_ADD    = 2'd0,
        FN_REMOVE = 2'd1,
        FN_PURGE  = 2'd2,
        FN_NONE   = 2'd3
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_NEW      = 3'd0,
        ST_INC      = 3'd1,
        ST_DEC      = 3'd2,
        ST_REL      = 3'd3,
        ST_NOTFOUND = 3'd4,
        ST_FULL     = 3'd5,
        ST_PREL     = 3'd6,
        ST_PEMPTY   = 3'd7
    } t_status;

    // per-cell operation
    typedef enum logic [2:0] {
        C_HOLD,
        C_INC,
        C_DEC,
        C_LOAD,
        C_SHIFT
    } t_cell_op;

    // row-wide action, resolved per cell by the top level
    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_INC,
        ACT_DEC,
        ACT_LOAD,
        ACT_CLOSE,
        ACT_SHIFT
    } t_action;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_PURGE
    } t_state;

    typedef struct packed {
        t_cell_op op;
        logic     live;
    } t_cell_ctl;

endpackage

// File: hw/rtl/refcount_handle_table.sv
// ----------------------------------------------------------------------------
// refcount_handle_table
// Table of resource handles with reference counts, built as a row of cells.
// ----------------------------------------------------------------------------
// An item is taken and registered, then executed in S_EXEC: all cells compare
// the handle at once and the row updates in that same cycle (count change,
// append at the fill point, or a one-place shift down to close a gap). A purge
// passes through S_EXEC and then releases one entry per cycle while the output
// register is free, head of the row first, while the whole row shifts down. The
// next item is taken once the row is idle; a result waiting in the output
// register only holds up a further update.
// func: 0 add, 1 remove, 2 purge, 3 ignored.
module refcount_handle_table
    import rht_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    input  logic [31:0]         i_s_axis_tdata,   // [31:0] handle
    input  logic [7:0]          i_s_axis_tuser,   // [1:0] func
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    output logic [47:0]         o_m_axis_tdata,   // [31:0] release_handle, [47:32] ref_count
    output logic [7:0]          o_m_axis_tuser,   // [2:0] status
    output logic                o_m_axis_tlast
);

    localparam int OCC_W = $clog2(CAPACITY + 1);

    t_state              r_state, n_state;
    t_func               r_func;
    logic [HANDLE_W-1:0] r_handle;
    logic [OCC_W-1:0]    r_occ, n_occ;

    logic                r_out_valid;
    t_status             r_out_status;
    logic [HANDLE_W-1:0] r_out_handle;
    logic [COUNT_W-1:0]  r_out_count;
    logic                r_out_last;

    logic                in_fire;
    logic                slot_free;
    logic                emit;
    t_status             e_status;
    logic [HANDLE_W-1:0] e_handle;
    logic [COUNT_W-1:0]  e_count;
    logic                e_last;
    t_action             action;

    logic [HANDLE_W-1:0] cell_key   [CAPACITY];
    logic [COUNT_W-1:0]  cell_count [CAPACITY];
    t_cell_ctl           cell_ctl   [CAPACITY];
    logic [CAPACITY-1:0] hit;
    logic [CAPACITY-1:0] at_or_after;
    logic                any_hit;
    logic [COUNT_W-1:0]  hit_count;
    logic                full;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_fire         = i_s_axis_tvalid && o_s_axis_tready;
    assign slot_free       = !r_out_valid || i_m_axis_tready;
    assign any_hit         = |hit;
    assign full            = (r_occ == OCC_W'(CAPACITY));

    always_comb begin
        hit_count = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            hit_count = hit_count | (hit[k] ? cell_count[k] : '0);
        end
    end

    always_comb begin
        at_or_after[0] = hit[0];
        for (int k = 1; k < CAPACITY; k++) begin
            at_or_after[k] = at_or_after[k-1] | hit[k];
        end
    end

    // cell row
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [HANDLE_W-1:0] next_key;
        logic [COUNT_W-1:0]  next_count;

        if (g == CAPACITY - 1) begin : g_tail
            assign next_key   = '0;
            assign next_count = '0;
        end else begin : g_link
            assign next_key   = cell_key[g+1];
            assign next_count = cell_count[g+1];
        end

        always_comb begin
            cell_ctl[g].live = (OCC_W'(g) < r_occ);
            case (action)
                ACT_INC:   cell_ctl[g].op = hit[g] ? C_INC : C_HOLD;
                ACT_DEC:   cell_ctl[g].op = hit[g] ? C_DEC : C_HOLD;
                ACT_LOAD:  cell_ctl[g].op = (OCC_W'(g) == r_occ) ? C_LOAD : C_HOLD;
                ACT_CLOSE: cell_ctl[g].op = at_or_after[g] ? C_SHIFT : C_HOLD;
                ACT_SHIFT: cell_ctl[g].op = C_SHIFT;
                default:   cell_ctl[g].op = C_HOLD;
            endcase
        end

        rht_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (cell_ctl[g]),
            .i_handle     (r_handle),
            .i_next_key   (next_key),
            .i_next_count (next_count),
            .o_key        (cell_key[g]),
            .o_count      (cell_count[g]),
            .o_hit        (hit[g])
        );
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (r_func == FN_NONE) begin
                    n_state = S_IDLE;
                end else if (r_func == FN_PURGE && r_occ != '0) begin
                    n_state = S_PURGE;
                end else if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            S_PURGE: begin
                if (slot_free && r_occ == OCC_W'(1)) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs and row action
    always_comb begin
        emit     = 1'b0;
        e_status = ST_NEW;
        e_handle = '0;
        e_count  = '0;
        e_last   = 1'b1;
        action   = ACT_NONE;
        n_occ    = r_occ;
        case (r_state)
            S_EXEC: begin
                if (slot_free) begin
                    case (r_func)
                        FN_ADD: begin
                            emit = 1'b1;
                            if (any_hit) begin
                                action   = ACT_INC;
                                e_status = ST_INC;
                                e_count  = (hit_count == COUNT_MAX) ? hit_count
                                         : hit_count + COUNT_W'(1);
                            end else if (full) begin
                                e_status = ST_FULL;
                            end else begin
                                action   = ACT_LOAD;
                                e_status = ST_NEW;
                                e_count  = COUNT_W'(1);
                                n_occ    = r_occ + OCC_W'(1);
                            end
                        end
                        FN_REMOVE: begin
                            emit = 1'b1;
                            if (!any_hit) begin
                                e_status = ST_NOTFOUND;
                            end else if (hit_count > COUNT_W'(1)) begin
                                action   = ACT_DEC;
                                e_status = ST_DEC;
                                e_count  = hit_count - COUNT_W'(1);
                            end else begin
                                action   = ACT_CLOSE;
                                e_status = ST_REL;
                                e_handle = r_handle;
                                n_occ    = r_occ - OCC_W'(1);
                            end
                        end
                        FN_PURGE: begin
                            if (r_occ == '0) begin
                                emit     = 1'b1;
                                e_status = ST_PEMPTY;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_PURGE: begin
                if (slot_free) begin
                    emit     = 1'b1;
                    action   = ACT_SHIFT;
                    e_status = ST_PREL;
                    e_handle = cell_key[0];
                    e_last   = (r_occ == OCC_W'(1));
                    n_occ    = r_occ - OCC_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_occ   <= n_occ;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_func   <= t_func'(i_s_axis_tuser[FUNC_W-1:0]);
            r_handle <= i_s_axis_tdata;
        end
        if (emit) begin
            r_out_status <= e_status;
            r_out_handle <= e_handle;
            r_out_count  <= e_count;
            r_out_last   <= e_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_count, r_out_handle};
    assign o_m_axis_tuser  = {{(8 - STATUS_W){1'b0}}, r_out_status};
    assign o_m_axis_tlast  = r_out_last;

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OCC_W'(CAPACITY))
        else $error("occupancy above capacity");

    a_unique_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(hit))
        else $error("handle matched in more than one cell");

    a_purge_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_PURGE |-> r_occ != '0)
        else $error("purge running on an empty row");

    a_full_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_status == ST_FULL |-> full)
        else $error("full reported below capacity");

    a_release_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit && (e_status == ST_REL || e_status == ST_PREL)
        |=> r_occ == $past(r_occ) - OCC_W'(1))
        else $error("release without occupancy drop");

endmodule

// File: hw/rtl/rht_cell.sv
// ----------------------------------------------------------------------------
// rht_cell
// One table entry: handle and count, match against the broadcast handle,
// shift from the upper neighbor.
// ----------------------------------------------------------------------------
module rht_cell
    import rht_pkg::*;
(
    input  logic                i_clk,
    input  t_cell_ctl           i_ctl,
    input  logic [HANDLE_W-1:0] i_handle,
    input  logic [HANDLE_W-1:0] i_next_key,
    input  logic [COUNT_W-1:0]  i_next_count,
    output logic [HANDLE_W-1:0] o_key,
    output logic [COUNT_W-1:0]  o_count,
    output logic                o_hit
);

    logic [HANDLE_W-1:0] r_key;
    logic [COUNT_W-1:0]  r_count;
    logic [HANDLE_W-1:0] n_key;
    logic [COUNT_W-1:0]  n_count;

    always_comb begin
        n_key   = r_key;
        n_count = r_count;
        case (i_ctl.op)
            C_INC: begin
                if (r_count != COUNT_MAX) begin
                    n_count = r_count + COUNT_W'(1);
                end
            end
            C_DEC: begin
                n_count = r_count - COUNT_W'(1);
            end
            C_LOAD: begin
                n_key   = i_handle;
                n_count = COUNT_W'(1);
            end
            C_SHIFT: begin
                n_key   = i_next_key;
                n_count = i_next_count;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_count <= n_count;
    end

    assign o_key   = r_key;
    assign o_count = r_count;
    assign o_hit   = i_ctl.live && (r_key == i_handle);

endmodule

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stream-level check of refcount_handle_table. A directed table covers
// empty-table cases, a full table, head, middle and tail releases, purges
// and the unused code. Random traffic follows over a small handle pool so
// that hits, fills and releases are frequent. Directed rows marked typed carry
// their expected result; every other result is taken from an in-bench model.
// ----------------------------------------------------------------------------
module testbench;
    import rht_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY       = CAPACITY_DEF;
    localparam int ITEMS_PER_PASS = 70;
    localparam int POOL_SIZE      = 20;
    localparam int HOLD_LEN       = 300;
    localparam int DRAIN_CYCLES   = 2 * CAPACITY + 20;
    localparam int CYCLE_LIMIT    = 3_000_000;

    typedef struct packed {
        t_status     status;
        logic [31:0] rel_handle;
        logic [15:0] count;
        logic        last;
    } t_result;

    typedef struct {
        t_func       f;
        logic [31:0] handle;
        int unsigned reps;
        logic [31:0] stride;
        bit          typed;
        t_result     want;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [31:0] s_tdata = '0;   // [31:0] handle
    logic [7:0]  s_tuser = '0;   // [1:0] func
    logic        m_tready = 1'b0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [47:0] o_m_axis_tdata;  // [31:0] release_handle, [47:32] ref_count
    logic [7:0]  o_m_axis_tuser;  // [2:0] status
    logic        o_m_axis_tlast;

    // table model
    logic [31:0] slot_handle [CAPACITY];
    logic [15:0] slot_count [CAPACITY];
    int          fill = 0;

    t_result     step_results [$];
    t_result     expected_results [$];
    t_stim_row   directed_rows [22];
    logic [31:0] handle_pool [POOL_SIZE];

    int          n_errors = 0;
    int          snd_idle_pct = 0;
    int          rcv_idle_pct = 0;
    bit          hold_req = 1'b0;
    bit          hold_done = 1'b0;
    int          hold_cycles = 0;
    longint      cycle_count = 0;

    refcount_handle_table #(.CAPACITY(CAPACITY)) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void table_apply(input t_func f, input logic [31:0] h);
        int slot;
        slot = -1;
        step_results.delete();
        for (int i = 0; i < fill; i++) begin
            if (slot < 0 && slot_handle[i] == h) slot = i;
        end
        case (f)
            FN_ADD: begin
                if (slot >= 0) begin
                    if (slot_count[slot] != COUNT_MAX) slot_count[slot]++;
                    step_results.push_back(t_result'{ST_INC, 32'h0, slot_count[slot], 1'b1});
                end else if (fill >= CAPACITY) begin
                    step_results.push_back(t_result'{ST_FULL, 32'h0, 16'h0, 1'b1});
                end else begin
                    slot_handle[fill] = h;
                    slot_count[fill] = 16'd1;
                    fill++;
                    step_results.push_back(t_result'{ST_NEW, 32'h0, 16'd1, 1'b1});
                end
            end
            FN_REMOVE: begin
                if (slot < 0) begin
                    step_results.push_back(t_result'{ST_NOTFOUND, 32'h0, 16'h0, 1'b1});
                end else if (slot_count[slot] > 16'd1) begin
                    slot_count[slot]--;
                    step_results.push_back(t_result'{ST_DEC, 32'h0, slot_count[slot], 1'b1});
                end else begin
                    for (int i = slot; i + 1 < fill; i++) begin
                        slot_handle[i] = slot_handle[i + 1];
                        slot_count[i] = slot_count[i + 1];
                    end
                    fill--;
                    step_results.push_back(t_result'{ST_REL, h, 16'h0, 1'b1});
                end
            end
            FN_PURGE: begin
                if (fill == 0) begin
                    step_results.push_back(t_result'{ST_PEMPTY, 32'h0, 16'h0, 1'b1});
                end else begin
                    for (int i = 0; i < fill; i++) begin
                        step_results.push_back(
                            t_result'{ST_PREL, slot_handle[i], 16'h0, i + 1 == fill});
                    end
                    fill = 0;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void report(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        n_errors++;
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
    endfunction

    function automatic void check_result(input t_result got);
        t_result want;
        if (expected_results.size() == 0) begin
            n_errors++;
            $display("%0t: unexpected result, expected none, actual status %0d handle 0x%0h",
                     $time, got.status, got.rel_handle);
            return;
        end
        want = expected_results.pop_front();
        if (got.status != want.status) report("status", want.status, got.status);
        if (got.rel_handle != want.rel_handle)
            report("release_handle", want.rel_handle, got.rel_handle);
        if (got.count != want.count) report("ref_count", want.count, got.count);
        if (got.last != want.last) report("last", want.last, got.last);
    endfunction

    // result side: checking, random back-pressure and one long hold-off
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_tready && o_m_axis_tvalid)
                check_result(t_result'{t_status'(o_m_axis_tuser[2:0]), o_m_axis_tdata[31:0],
                                       o_m_axis_tdata[47:32], o_m_axis_tlast});
            if (hold_req && !hold_done) begin
                if (hold_cycles < HOLD_LEN) begin
                    m_tready <= 1'b0;
                    hold_cycles++;
                end else begin
                    hold_done = 1'b1;
                    m_tready <= 1'b1;
                end
            end else begin
                m_tready <= ($urandom_range(99) >= rcv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout", $time);
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_item(input t_func f, input logic [31:0] h, input bit typed,
                             input t_result want);
        while ($urandom_range(99) < snd_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= h;
        s_tuser  <= {6'b0, f};
        do @(posedge i_clk); while (!o_s_axis_tready);
        table_apply(f, h);
        if (typed) begin
            expected_results.push_back(want);
        end else begin
            foreach (step_results[i]) expected_results.push_back(step_results[i]);
        end
    endtask

    initial begin
        int          sent;
        int          pick;
        t_func       f;
        logic [31:0] h;

        directed_rows = '{
            '{FN_PURGE,  32'h0,        1,     32'h0, 1'b1, '{ST_PEMPTY, 32'h0, 16'h0, 1'b1}},
            '{FN_REMOVE, 32'h0,        1,     32'h0, 1'b1, '{ST_NOTFOUND, 32'h0, 16'h0, 1'b1}},
            '{FN_ADD,    32'h0,        1,     32'h0, 1'b1, '{ST_NEW, 32'h0, 16'd1, 1'b1}},
            '{FN_ADD,    32'hFFFFFFFF, 1,     32'h0, 1'b1, '{ST_NEW, 32'h0, 16'd1, 1'b1}},
            '{FN_ADD,    32'h0,        1,     32'h0, 1'b1, '{ST_INC, 32'h0, 16'd2, 1'b1}},
            '{FN_REMOVE, 32'hFFFFFFFF, 1,     32'h0, 1'b1,
              '{ST_REL, 32'hFFFFFFFF, 16'h0, 1'b1}},
            '{FN_NONE,   32'h3C3C3C3C, 1,     32'h0, 1'b0, '0},
            '{FN_ADD,    32'hA5A50000, 15,    32'h1, 1'b0, '0},
            '{FN_ADD,    32'h5A5A5A5A, 1,     32'h0, 1'b1, '{ST_FULL, 32'h0, 16'h0, 1'b1}},
            '{FN_REMOVE, 32'h0,        1,     32'h0, 1'b1, '{ST_DEC, 32'h0, 16'd1, 1'b1}},
            '{FN_REMOVE, 32'hA5A50006, 1,     32'h0, 1'b1,
              '{ST_REL, 32'hA5A50006, 16'h0, 1'b1}},
            '{FN_ADD,    32'hA5A50006, 1,     32'h0, 1'b1, '{ST_NEW, 32'h0, 16'd1, 1'b1}},
            '{FN_ADD,    32'hA5A50003, 1,     32'h0, 1'b1, '{ST_INC, 32'h0, 16'd2, 1'b1}},
            '{FN_REMOVE, 32'hA5A50003, 1,     32'h0, 1'b1, '{ST_DEC, 32'h0, 16'd1, 1'b1}},
            '{FN_REMOVE, 32'h12345678, 1,     32'h0, 1'b1,
              '{ST_NOTFOUND, 32'h0, 16'h0, 1'b1}},
            '{FN_PURGE,  32'h0,        1,     32'h0, 1'b0, '0},
            '{FN_PURGE,  32'h0,        1,     32'h0, 1'b1, '{ST_PEMPTY, 32'h0, 16'h0, 1'b1}},
            '{FN_ADD,    32'h80000001, 1,     32'h0, 1'b1, '{ST_NEW, 32'h0, 16'd1, 1'b1}},
            '{FN_ADD,    32'h7FFFFFFE, 1,     32'h0, 1'b1, '{ST_NEW, 32'h0, 16'd1, 1'b1}},
            '{FN_REMOVE, 32'h80000001, 1,     32'h0, 1'b1,
              '{ST_REL, 32'h80000001, 16'h0, 1'b1}},
            '{FN_NONE,   32'hFFFFFFFF, 1,     32'h0, 1'b0, '0},
            '{FN_PURGE,  32'h0,        1,     32'h0, 1'b0, '0}
        };

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        snd_idle_pct = 19;
        rcv_idle_pct = 46;
        foreach (directed_rows[r]) begin
            for (int unsigned k = 0; k < directed_rows[r].reps; k++)
                send_item(directed_rows[r].f, directed_rows[r].handle + k * directed_rows[r].stride,
                          directed_rows[r].typed, directed_rows[r].want);
        end

        for (int pass = 0; pass < 3; pass++) begin
            snd_idle_pct = (pass == 0) ? 19 : (pass == 1) ? 46 : 0;
            rcv_idle_pct = (pass == 0) ? 46 : (pass == 1) ? 19 : 0;
            if (pass == 0) hold_req = 1'b1;
            foreach (handle_pool[i]) handle_pool[i] = $urandom();
            sent = 0;
            while (sent < ITEMS_PER_PASS) begin
                pick = $urandom_range(99);
                h = handle_pool[$urandom_range(POOL_SIZE - 1)];
                if (pick < 45) begin
                    f = FN_ADD;
                end else if (pick < 80) begin
                    f = FN_REMOVE;
                end else if (pick < 85) begin
                    f = FN_PURGE;
                end else if (pick < 90) begin
                    f = FN_NONE;
                    h = $urandom();
                end else begin
                    f = (pick < 95) ? FN_ADD : FN_REMOVE;
                    h = $urandom();
                end
                send_item(f, h, 1'b0, '0);
                if (f != FN_NONE) sent++;
            end
        end
        s_tvalid <= 1'b0;

        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (n_errors == 0 && expected_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/rht_pkg.sv
hw/rtl/rht_cell.sv
hw/rtl/refcount_handle_table.sv
dv/testbench.sv
